/* rtl/core/swlf_pkg.sv */
package swlf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [22:0] GRAVITY_RESET   = 23'd642908;
    localparam logic [30:0] DIFFUSION_RESET = 31'd393216;

    typedef enum logic {
        REG_GRAVITY   = 1'b0,
        REG_DIFFUSION = 1'b1
    } t_reg_idx;

    // One request after classification: magnitudes and signs ready for the multipliers.
    typedef struct packed {
        logic [30:0] hl;
        logic [30:0] hr;
        logic [31:0] al;
        logic [31:0] ar;
        logic [32:0] msum_mag;
        logic        msum_neg;
        logic [30:0] dh_mag;
        logic        dh_neg;
        logic [32:0] dm_mag;
        logic        dm_neg;
        logic [31:0] nmag;
        logic        nneg;
        logic        bad;
    } t_item;

    typedef struct packed {
        logic signed [31:0] mass;
        logic signed [31:0] mom;
        logic               sat;
        logic               bad;
    } t_result;

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } t_sat;

    function automatic t_sat sat32(input logic signed [127:0] v);
        t_sat r;
        if ((&v[127:31]) || !(|v[127:31])) begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end else begin
            r.val  = v[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r.clip = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [127:0] neg_if(input logic [127:0] m, input logic n);
        logic signed [127:0] r;
        r = n ? $signed(-m) : $signed(m);
        return r;
    endfunction

endpackage

/* rtl/core/shallow_water_lax_friedrichs_flux_core.sv */
// Channel   Direction  Handshake           Contents
// input     in         push / full         heights, momenta, normal scale
// result    out        pop / empty         mass and momentum flux, flags
// config    in         APB psel/penable    gravity at 0x0, diffusion at 0x4
//
// One request is taken per cycle when no stall is present; its path is set
// mostly by the 63-stage divider between back stages 3 and 4.
// Reset is synchronous: it empties both queues and the pipeline and restores
// the register defaults; no memory needs clearing.
// The back end halts only while its last stage holds a result and the output
// queue is full; the front keeps taking requests until the middle queue fills.
module shallow_water_lax_friedrichs_flux_core #(
    parameter int FRAC_BITS = swlf_pkg::FRAC_BITS_DEF,
    parameter int MID_DEPTH = swlf_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = swlf_pkg::OUT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [30:0]        i_height_left,
    input  logic signed [31:0] i_momentum_left,
    input  logic [30:0]        i_height_right,
    input  logic signed [31:0] i_momentum_right,
    input  logic signed [31:0] i_normal_scale,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_mass_flux,
    output logic signed [31:0] o_momentum_flux,
    output logic               o_saturated,
    output logic               o_bad_height,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = $bits(swlf_pkg::t_item);
    localparam int RW = $bits(swlf_pkg::t_result);

    logic [22:0]        r_gravity;
    logic [30:0]        r_diffusion;
    swlf_pkg::t_reg_idx idx;
    logic               wr;

    assign pready = 1'b1;
    assign idx    = swlf_pkg::t_reg_idx'(paddr[2]);
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= swlf_pkg::GRAVITY_RESET;
            r_diffusion <= swlf_pkg::DIFFUSION_RESET;
        end else if (wr) begin
            unique case (idx)
                swlf_pkg::REG_GRAVITY:   r_gravity   <= pwdata[22:0];
                swlf_pkg::REG_DIFFUSION: r_diffusion <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            swlf_pkg::REG_GRAVITY:   prdata = {9'b0, r_gravity};
            swlf_pkg::REG_DIFFUSION: prdata = {1'b0, r_diffusion};
            default:                 prdata = '0;
        endcase
    end

    logic              f_valid, mid_full, mid_empty, mid_pop;
    swlf_pkg::t_item   f_item;
    logic [IW-1:0]     mid_data;
    logic              out_push, out_full;
    swlf_pkg::t_result b_res, o_res;
    logic [RW-1:0]     out_data;

    swlf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_height_left    (i_height_left),
        .i_momentum_left  (i_momentum_left),
        .i_height_right   (i_height_right),
        .i_momentum_right (i_momentum_right),
        .i_normal_scale   (i_normal_scale),
        .i_q_full         (mid_full),
        .o_valid          (f_valid),
        .o_item           (f_item)
    );

    swlf_fifo #(
        .W     (IW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_pop   (mid_pop),
        .i_data  (f_item),
        .o_data  (mid_data),
        .o_full  (mid_full),
        .o_empty (mid_empty)
    );

    swlf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_gravity         (r_gravity),
        .i_diffusion_coeff (r_diffusion),
        .i_q_valid         (~mid_empty),
        .o_q_pop           (mid_pop),
        .i_item            (swlf_pkg::t_item'(mid_data)),
        .i_out_full        (out_full),
        .o_push            (out_push),
        .o_res             (b_res)
    );

    swlf_fifo #(
        .W     (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_pop   (pop & ~empty),
        .i_data  (b_res),
        .o_data  (out_data),
        .o_full  (out_full),
        .o_empty (empty)
    );

    assign o_res           = swlf_pkg::t_result'(out_data);
    assign o_mass_flux     = o_res.mass;
    assign o_momentum_flux = o_res.mom;
    assign o_saturated     = o_res.sat;
    assign o_bad_height    = o_res.bad;

endmodule

/* rtl/core/swlf_fifo.sv */
module swlf_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic         i_pop,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (i_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

/* rtl/core/swlf_front.sv */
module swlf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [30:0]           i_height_left,
    input  logic signed [31:0]    i_momentum_left,
    input  logic [30:0]           i_height_right,
    input  logic signed [31:0]    i_momentum_right,
    input  logic signed [31:0]    i_normal_scale,
    input  logic                  i_q_full,
    output logic                  o_valid,
    output swlf_pkg::t_item       o_item
);

    logic              r_fv;
    swlf_pkg::t_item   r_item, n_item;
    logic              accept, move;
    logic signed [32:0] msum, dm;
    logic signed [31:0] dh;

    assign move   = r_fv & ~i_q_full;
    assign o_full = r_fv & i_q_full;
    assign accept = i_push & ~o_full;

    always_comb begin
        msum = {i_momentum_left[31], i_momentum_left} + {i_momentum_right[31], i_momentum_right};
        dm   = {i_momentum_right[31], i_momentum_right} - {i_momentum_left[31], i_momentum_left};
        dh   = $signed({1'b0, i_height_right}) - $signed({1'b0, i_height_left});

        n_item.hl       = i_height_left;
        n_item.hr       = i_height_right;
        n_item.al       = i_momentum_left[31] ? 32'(-i_momentum_left) : 32'(i_momentum_left);
        n_item.ar       = i_momentum_right[31] ? 32'(-i_momentum_right) : 32'(i_momentum_right);
        n_item.msum_neg = msum[32];
        n_item.msum_mag = msum[32] ? 33'(-msum) : 33'(msum);
        n_item.dh_neg   = dh[31];
        n_item.dh_mag   = dh[31] ? 31'(-dh) : 31'(dh);
        n_item.dm_neg   = dm[32];
        n_item.dm_mag   = dm[32] ? 33'(-dm) : 33'(dm);
        n_item.nneg     = i_normal_scale[31];
        n_item.nmag     = i_normal_scale[31] ? 32'(-i_normal_scale) : 32'(i_normal_scale);
        n_item.bad      = (i_height_left == '0) || (i_height_right == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= accept | (r_fv & ~move);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = move;
    assign o_item  = r_item;

endmodule

/* rtl/core/swlf_div.sv */
module swlf_div #(
    parameter int NW = 63,
    parameter int DW = 31,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num_a,
    input  logic [NW-1:0] i_num_b,
    input  logic [DW-1:0] i_den_a,
    input  logic [DW-1:0] i_den_b,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quo_a,
    output logic [NW-1:0] o_quo_b,
    output logic [PW-1:0] o_pay
);

    // Restoring division, one quotient bit per stage; the dividend register
    // shifts out its top bit and takes the new quotient bit at the bottom.
    function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] rem,
                                                  input logic [NW-1:0] num,
                                                  input logic [DW-1:0] den);
        logic [DW:0]   trial;
        logic [DW-1:0] nrem;
        logic          q;
        trial = {rem, num[NW-1]};
        if (trial >= {1'b0, den}) begin
            nrem = DW'(trial - {1'b0, den});
            q    = 1'b1;
        end else begin
            nrem = trial[DW-1:0];
            q    = 1'b0;
        end
        return {nrem, num[NW-2:0], q};
    endfunction

    logic [NW-1:0] r_v;
    logic [DW-1:0] r_rem_a [NW];
    logic [DW-1:0] r_rem_b [NW];
    logic [NW-1:0] r_num_a [NW];
    logic [NW-1:0] r_num_b [NW];
    logic [DW-1:0] r_den_a [NW];
    logic [DW-1:0] r_den_b [NW];
    logic [PW-1:0] r_pay   [NW];
    logic [DW-1:0] n_rem_a [NW];
    logic [DW-1:0] n_rem_b [NW];
    logic [NW-1:0] n_num_a [NW];
    logic [NW-1:0] n_num_b [NW];

    always_comb begin
        {n_rem_a[0], n_num_a[0]} = div_step('0, i_num_a, i_den_a);
        {n_rem_b[0], n_num_b[0]} = div_step('0, i_num_b, i_den_b);
        for (int s = 1; s < NW; s++) begin
            {n_rem_a[s], n_num_a[s]} = div_step(r_rem_a[s-1], r_num_a[s-1], r_den_a[s-1]);
            {n_rem_b[s], n_num_b[s]} = div_step(r_rem_b[s-1], r_num_b[s-1], r_den_b[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[NW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_den_a[0] <= i_den_a;
            r_den_b[0] <= i_den_b;
            r_pay[0]   <= i_pay;
            for (int s = 0; s < NW; s++) begin
                r_rem_a[s] <= n_rem_a[s];
                r_rem_b[s] <= n_rem_b[s];
                r_num_a[s] <= n_num_a[s];
                r_num_b[s] <= n_num_b[s];
            end
            for (int s = 1; s < NW; s++) begin
                r_den_a[s] <= r_den_a[s-1];
                r_den_b[s] <= r_den_b[s-1];
                r_pay[s]   <= r_pay[s-1];
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo_a = r_num_a[NW-1];
    assign o_quo_b = r_num_b[NW-1];
    assign o_pay   = r_pay[NW-1];

endmodule

/* rtl/core/swlf_back.sv */
module swlf_back #(
    parameter int FRAC_BITS = swlf_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [22:0]       i_gravity,
    input  logic [30:0]       i_diffusion_coeff,
    input  logic              i_q_valid,
    output logic              o_q_pop,
    input  swlf_pkg::t_item   i_item,
    input  logic              i_out_full,
    output logic              o_push,
    output swlf_pkg::t_result o_res
);

    localparam int F     = FRAC_BITS;
    localparam int KW    = 63;
    localparam int POTSW = 85 - 2 * F;
    localparam int PSW   = ((KW > POTSW) ? KW : POTSW) + 2;
    localparam int NCH   = (PSW + 31) / 32;
    localparam int PSX   = 32 * NCH;
    localparam int T1W   = PSX + 32 - (F + 1);
    localparam int T2W   = 65 - F;
    localparam int PW    = POTSW + 32 + 1 + T2W + 32 + 1 + 1;

    logic ce;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic dv;

    // The whole back end moves together; it halts only while a finished
    // result cannot enter the output queue.
    assign ce      = ~(r_v7 & i_out_full);
    assign o_q_pop = ce & i_q_valid;
    assign o_push  = r_v7 & ~i_out_full;

    // Stage 1: all products of the input magnitudes.
    logic [63:0] sqa_w, sqb_w;
    logic [62:0] r1_sqa, r1_sqb;
    logic [61:0] r1_hhl, r1_hhr;
    logic [64:0] r1_m1;
    logic [61:0] r1_m2;
    logic [63:0] r1_d2;
    logic        r1_mneg, r1_dh_neg, r1_dm_neg, r1_nneg, r1_bad;
    logic [31:0] r1_nmag;
    logic [30:0] r1_dl, r1_dr;

    assign sqa_w = i_item.al * i_item.al;
    assign sqb_w = i_item.ar * i_item.ar;

    // Stage 2: gravity products, mass flux and the momentum diffusion term.
    logic [53:0]        pl_l, ph_l, pl_r, ph_r;
    logic signed [127:0] ms1, ms2, d2s;
    swlf_pkg::t_sat      mass_s;
    logic [53:0]         r2_pl_l, r2_ph_l, r2_pl_r, r2_ph_r;
    logic [62:0]         r2_sqa, r2_sqb;
    logic [30:0]         r2_dl, r2_dr;
    logic [31:0]         r2_mass, r2_nmag;
    logic                r2_mclip, r2_nneg, r2_bad;
    logic signed [T2W-1:0] r2_t2;

    assign pl_l = i_gravity * r1_hhl[30:0];
    assign ph_l = i_gravity * r1_hhl[61:31];
    assign pl_r = i_gravity * r1_hhr[30:0];
    assign ph_r = i_gravity * r1_hhr[61:31];

    always_comb begin
        ms1    = swlf_pkg::neg_if({63'b0, r1_m1} >> (F + 1), r1_mneg ^ r1_nneg);
        ms2    = swlf_pkg::neg_if({66'b0, r1_m2} >> F, r1_dh_neg);
        mass_s = swlf_pkg::sat32(ms1 - ms2);
        d2s    = swlf_pkg::neg_if({64'b0, r1_d2} >> F, r1_dm_neg);
    end

    // Stage 3: potential terms of both sides.
    logic [127:0]        pot_w;
    logic [POTSW-1:0]    r3_pots;
    logic [62:0]         r3_sqa, r3_sqb;
    logic [30:0]         r3_dl, r3_dr;
    logic [31:0]         r3_mass, r3_nmag;
    logic                r3_mclip, r3_nneg, r3_bad;
    logic signed [T2W-1:0] r3_t2;

    always_comb begin
        pot_w = ((({74'b0, r2_pl_l}) + ({74'b0, r2_ph_l} << 31)) >> (2 * F + 1))
              + ((({74'b0, r2_pl_r}) + ({74'b0, r2_ph_r} << 31)) >> (2 * F + 1));
    end

    // Divider: hu^2/h for both sides, everything else rides along.
    logic [PW-1:0]         d_pay_in, d_pay_out;
    logic [KW-1:0]         qa, qb;
    logic [POTSW-1:0]      p_pots;
    logic [31:0]           p_mass, p_nmag;
    logic                  p_mclip, p_nneg, p_bad;
    logic signed [T2W-1:0] p_t2;

    assign d_pay_in = {r3_pots, r3_mass, r3_mclip, r3_t2, r3_nmag, r3_nneg, r3_bad};
    assign {p_pots, p_mass, p_mclip, p_t2, p_nmag, p_nneg, p_bad} = d_pay_out;

    swlf_div #(
        .NW (KW),
        .DW (31),
        .PW (PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_v3),
        .i_num_a (r3_sqa),
        .i_num_b (r3_sqb),
        .i_den_a (r3_dl),
        .i_den_b (r3_dr),
        .i_pay   (d_pay_in),
        .o_valid (dv),
        .o_quo_a (qa),
        .o_quo_b (qb),
        .o_pay   (d_pay_out)
    );

    // Stages 4 to 7: sum of physical fluxes, times n, minus diffusion.
    logic [127:0]          psum_w;
    logic [PSW-1:0]        r4_psum;
    logic [PSX-1:0]        psx;
    logic [63:0]           r5_p [NCH];
    logic [127:0]          prod_w;
    logic [T1W-1:0]        r6_t1;
    logic [31:0]           r4_mass, r4_nmag, r5_mass, r6_mass;
    logic                  r4_mclip, r4_nneg, r4_bad;
    logic                  r5_mclip, r5_nneg, r5_bad;
    logic                  r6_mclip, r6_nneg, r6_bad;
    logic signed [T2W-1:0] r4_t2, r5_t2, r6_t2;
    logic signed [127:0]   t1s, t2s;
    swlf_pkg::t_sat        mom_s;
    swlf_pkg::t_result     n_res, r7_res;

    assign psum_w = 128'(qa) + 128'(qb) + 128'(p_pots);
    assign psx    = PSX'(r4_psum);

    always_comb begin
        prod_w = '0;
        for (int k = 0; k < NCH; k++) begin
            prod_w = prod_w + (128'(r5_p[k]) << (32 * k));
        end
    end

    always_comb begin
        t1s   = swlf_pkg::neg_if(128'(r6_t1), r6_nneg);
        t2s   = 128'(r6_t2);
        mom_s = swlf_pkg::sat32(t1s - t2s);
        if (r6_bad) begin
            n_res.mass = '0;
            n_res.mom  = '0;
            n_res.sat  = 1'b0;
            n_res.bad  = 1'b1;
        end else begin
            n_res.mass = r6_mass;
            n_res.mom  = mom_s.val;
            n_res.sat  = r6_mclip | mom_s.clip;
            n_res.bad  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (ce) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= dv;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_sqa    <= sqa_w[62:0];
            r1_sqb    <= sqb_w[62:0];
            r1_hhl    <= i_item.hl * i_item.hl;
            r1_hhr    <= i_item.hr * i_item.hr;
            r1_m1     <= i_item.msum_mag * i_item.nmag;
            r1_m2     <= i_item.dh_mag * i_diffusion_coeff;
            r1_d2     <= i_item.dm_mag * i_diffusion_coeff;
            r1_mneg   <= i_item.msum_neg;
            r1_dh_neg <= i_item.dh_neg;
            r1_dm_neg <= i_item.dm_neg;
            r1_nneg   <= i_item.nneg;
            r1_nmag   <= i_item.nmag;
            r1_bad    <= i_item.bad;
            // A zero height would stall nothing, but keep the divisor sane.
            r1_dl     <= i_item.bad ? 31'd1 : i_item.hl;
            r1_dr     <= i_item.bad ? 31'd1 : i_item.hr;

            r2_pl_l  <= pl_l;
            r2_ph_l  <= ph_l;
            r2_pl_r  <= pl_r;
            r2_ph_r  <= ph_r;
            r2_sqa   <= r1_sqa;
            r2_sqb   <= r1_sqb;
            r2_dl    <= r1_dl;
            r2_dr    <= r1_dr;
            r2_mass  <= mass_s.val;
            r2_mclip <= mass_s.clip;
            r2_t2    <= d2s[T2W-1:0];
            r2_nmag  <= r1_nmag;
            r2_nneg  <= r1_nneg;
            r2_bad   <= r1_bad;

            r3_pots  <= pot_w[POTSW-1:0];
            r3_sqa   <= r2_sqa;
            r3_sqb   <= r2_sqb;
            r3_dl    <= r2_dl;
            r3_dr    <= r2_dr;
            r3_mass  <= r2_mass;
            r3_mclip <= r2_mclip;
            r3_t2    <= r2_t2;
            r3_nmag  <= r2_nmag;
            r3_nneg  <= r2_nneg;
            r3_bad   <= r2_bad;

            r4_psum  <= psum_w[PSW-1:0];
            r4_mass  <= p_mass;
            r4_mclip <= p_mclip;
            r4_t2    <= p_t2;
            r4_nmag  <= p_nmag;
            r4_nneg  <= p_nneg;
            r4_bad   <= p_bad;

            for (int k = 0; k < NCH; k++) begin
                r5_p[k] <= psx[32*k +: 32] * r4_nmag;
            end
            r5_mass  <= r4_mass;
            r5_mclip <= r4_mclip;
            r5_t2    <= r4_t2;
            r5_nneg  <= r4_nneg;
            r5_bad   <= r4_bad;

            r6_t1    <= prod_w[F+1 +: T1W];
            r6_mass  <= r5_mass;
            r6_mclip <= r5_mclip;
            r6_t2    <= r5_t2;
            r6_nneg  <= r5_nneg;
            r6_bad   <= r5_bad;

            r7_res   <= n_res;
        end
    end

    assign o_res = r7_res;

endmodule
